[src/fsd_pkg.sv]
package fsd_pkg;

    // geometry limits
    localparam int MAX_WIDTH   = 4096;
    localparam int LINE_AW     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CMP_W       = 18;
    localparam int CFG_DW      = 16;

    // pixel and error widths
    localparam int PIX_W       = 8;
    localparam int ERR_W       = 12;
    localparam int WIDE_W      = 16;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [PIX_W-1:0]           t_pixel;
    typedef logic [LINE_AW-1:0]         t_col;
    typedef logic [HEIGHT_W-1:0]        t_row;
    typedef logic signed [ERR_W-1:0]    t_err;
    typedef logic signed [WIDE_W-1:0]   t_wide;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // classified pixel request
    typedef struct packed {
        t_pixel pixel;
        t_col   col;
        logic   first_row;
        logic   last_col;
        logic   last_row;
    } t_item;

    // quantizer constants
    localparam t_wide ON_THRESH = 16'sd128;
    localparam t_wide DOT_LEVEL = 16'sd255;
    localparam t_wide WT_RIGHT  = 16'sd7;
    localparam t_wide WT_BLEFT  = 16'sd3;
    localparam t_wide WT_BELOW  = 16'sd5;
    localparam int    SHARE_DIV = 16;
    localparam int    SHARE_SH  = $clog2(SHARE_DIV);
    localparam t_wide DIV_BIAS  = t_wide'(SHARE_DIV - 1);
    localparam t_wide ERR_MAX   = t_wide'((1 << (ERR_W - 1)) - 1);
    localparam t_wide ERR_MIN   = -t_wide'(1 << (ERR_W - 1));

    // clamp to the signed error range
    function automatic t_err sat_err(input t_wide v);
        t_err r;
        if (v > ERR_MAX) begin
            r = ERR_W'(ERR_MAX);
        end else if (v < ERR_MIN) begin
            r = ERR_W'(ERR_MIN);
        end else begin
            r = ERR_W'(v);
        end
        return r;
    endfunction

    // divide by sixteen, rounding toward zero
    function automatic t_wide div_share(input t_wide v);
        t_wide bias;
        bias = v[WIDE_W-1] ? DIV_BIAS : '0;
        return (v + bias) >>> SHARE_SH;
    endfunction

endpackage

[src/fsd_pix_if.sv]
interface fsd_pix_if;
    import fsd_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_in;

    modport source(output valid, output pixel_in, input ready);
    modport sink(input valid, input pixel_in, output ready);
endinterface

[src/fsd_dot_if.sv]
interface fsd_dot_if;
    logic valid;
    logic ready;
    logic dot_on;
    logic row_end;
    logic frame_end;

    modport source(output valid, output dot_on, output row_end, output frame_end,
                   input ready);
    modport sink(input valid, input dot_on, input row_end, input frame_end,
                 output ready);
endinterface

[src/floyd_steinberg_dither_top.sv]
// an accepted pixel passes through the request queue, the error stage and the output register in turn
// throughput: one pixel per clock while the receiver takes dots, set by the single error stage and its carry loop
// the line buffer takes one write per cycle; the end-of-row entry waits until no below-left write needs the port
// reset (synchronous, active low) clears counters, carries, queue and valid flags,
// and sets width 640, height 480; the line buffer is not cleared, row 0 ignores what it reads
module floyd_steinberg_dither_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  fsd_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [fsd_pkg::CFG_DW-1:0]    i_cfg_data,
    fsd_pix_if.sink                       i_pix,
    fsd_dot_if.source                     o_dot
);
    import fsd_pkg::*;

    t_item front_item;
    logic  front_vld;
    logic  front_rdy;
    t_item queue_item;
    logic  queue_vld;
    logic  queue_rdy;

    // position and classification
    fsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .o_item     (front_item),
        .o_item_vld (front_vld),
        .i_item_rdy (front_rdy)
    );

    // request queue
    fsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (front_item),
        .i_vld   (front_vld),
        .o_rdy   (front_rdy),
        .o_item  (queue_item),
        .o_vld   (queue_vld),
        .i_rdy   (queue_rdy)
    );

    // error diffusion and output
    fsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (queue_item),
        .i_vld   (queue_vld),
        .o_rdy   (queue_rdy),
        .o_dot   (o_dot)
    );

endmodule

[src/fsd_ram.sv]
module fsd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/fsd_front.sv]
module fsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  fsd_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [fsd_pkg::CFG_DW-1:0]    i_cfg_data,
    fsd_pix_if.sink                       i_pix,
    output fsd_pkg::t_item                o_item,
    output logic                          o_item_vld,
    input  logic                          i_item_rdy
);
    import fsd_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    t_col                r_col, n_col;
    t_row                r_row, n_row;

    logic [CMP_W-1:0]    w_eff;
    logic [CMP_W-1:0]    h_eff;
    logic                last_col;
    logic                last_row;
    logic                accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(640);
            r_height <= HEIGHT_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry: zero means one, width capped at the line size
    always_comb begin
        if (r_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(r_width);
        end
        h_eff = (r_height == '0) ? CMP_W'(1) : CMP_W'(r_height);
    end

    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= w_eff;
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) >= h_eff;

    // handshake straight onto the queue
    assign i_pix.ready = i_item_rdy;
    assign o_item_vld  = i_pix.valid;
    assign accept      = i_pix.valid && i_item_rdy;

    always_comb begin
        o_item.pixel     = i_pix.pixel_in;
        o_item.col       = r_col;
        o_item.first_row = (r_row == '0);
        o_item.last_col  = last_col;
        o_item.last_row  = last_row;
    end

    // raster position counters
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + t_row'(1);
            end else begin
                n_col = r_col + t_col'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[src/fsd_queue.sv]
module fsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsd_pkg::t_item  i_item,
    input  logic            i_vld,
    output logic            o_rdy,
    output fsd_pkg::t_item  o_item,
    output logic            o_vld,
    input  logic            i_rdy
);
    import fsd_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wptr, n_wptr;
    logic [QUEUE_AW-1:0]  r_rptr, n_rptr;
    logic [QUEUE_AW:0]    r_cnt, n_cnt;
    logic                 push;
    logic                 pop;

    assign o_rdy  = (r_cnt != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rptr];
    assign push   = i_vld && o_rdy;
    assign pop    = o_vld && i_rdy;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // pointers and fill level
    always_comb begin
        n_wptr = push ? r_wptr + QUEUE_AW'(1) : r_wptr;
        n_rptr = pop  ? r_rptr + QUEUE_AW'(1) : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + (QUEUE_AW + 1)'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

[src/fsd_back.sv]
module fsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsd_pkg::t_item  i_item,
    input  logic            i_vld,
    output logic            o_rdy,
    fsd_dot_if.source       o_dot
);
    import fsd_pkg::*;

    // error stage
    t_item  r_b;
    logic   r_b_vld;
    logic   r_fwd_hit;
    t_err   r_fwd_val;

    // carries along the row
    t_err   r_right_carry, n_right_carry;
    t_err   r_pend_bl, n_pend_bl;
    t_err   r_pend_b, n_pend_b;

    // end-of-row entry not yet in the line buffer
    logic   r_tail_vld, n_tail_vld;
    t_col   r_tail_addr;
    t_err   r_tail_val;

    // output register
    logic   r_out_vld;
    logic   r_out_dot;
    logic   r_out_row_end;
    logic   r_out_frame_end;

    logic   b_done;
    logic   adv;
    t_err   ram_rdata;
    t_err   above;
    t_wide  sum_w;
    t_err   sum;
    logic   dot;
    t_wide  q;
    t_wide  share_r;
    t_wide  share_bl;
    t_wide  share_b;
    t_wide  share_br;
    t_err   bl_val;
    t_err   new_left;
    t_col   bl_addr;
    logic   main_we;
    logic   new_tail;
    logic   flush;
    logic   ram_we;
    t_col   ram_waddr;
    t_err   ram_wdata;
    logic   fwd_hit;
    t_err   fwd_val;

    // stage handshake
    assign b_done = r_b_vld && (!r_out_vld || o_dot.ready);
    assign o_rdy  = !r_b_vld || b_done;
    assign adv    = i_vld && o_rdy;

    // quantize the pixel with its diffused error
    always_comb begin
        above = r_b.first_row ? '0 : (r_fwd_hit ? r_fwd_val : ram_rdata);
        sum_w = $signed(WIDE_W'(r_b.pixel)) + WIDE_W'(r_right_carry) + WIDE_W'(above);
        sum   = sat_err(sum_w);
        dot   = WIDE_W'(sum) > ON_THRESH;
        q     = dot ? WIDE_W'(sum) - DOT_LEVEL : WIDE_W'(sum);
    end

    // error shares
    always_comb begin
        share_r  = div_share(q * WT_RIGHT);
        share_bl = div_share(q * WT_BLEFT);
        share_b  = div_share(q * WT_BELOW);
        share_br = div_share(q);
        bl_val   = sat_err(WIDE_W'(r_pend_bl) + share_bl);
        new_left = sat_err(WIDE_W'(r_pend_b) + share_b);
        bl_addr  = r_b.col - t_col'(1);
    end

    // next carries
    always_comb begin
        n_right_carry = r_right_carry;
        n_pend_bl     = r_pend_bl;
        n_pend_b      = r_pend_b;
        if (b_done) begin
            n_right_carry = r_b.last_col ? '0 : sat_err(share_r);
            if (r_b.last_row || r_b.last_col) begin
                n_pend_bl = '0;
                n_pend_b  = '0;
            end else begin
                n_pend_bl = new_left;
                n_pend_b  = sat_err(share_br);
            end
        end
    end

    // line buffer writes: below-left now, end-of-row entry when the port is free
    always_comb begin
        main_we    = b_done && !r_b.last_row && (r_b.col != '0);
        new_tail   = b_done && !r_b.last_row && r_b.last_col;
        flush      = r_tail_vld && !main_we;
        ram_we     = main_we || flush;
        ram_waddr  = main_we ? bl_addr : r_tail_addr;
        ram_wdata  = main_we ? bl_val : r_tail_val;
        n_tail_vld = new_tail || (r_tail_vld && !flush);
    end

    // forward entries that the read at this edge cannot see
    always_comb begin
        if (main_we && (bl_addr == i_item.col)) begin
            fwd_hit = 1'b1;
            fwd_val = bl_val;
        end else if (new_tail && (r_b.col == i_item.col)) begin
            fwd_hit = 1'b1;
            fwd_val = new_left;
        end else if (r_tail_vld && (r_tail_addr == i_item.col)) begin
            fwd_hit = 1'b1;
            fwd_val = r_tail_val;
        end else begin
            fwd_hit = 1'b0;
            fwd_val = r_tail_val;
        end
    end

    fsd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (i_item.col),
        .o_rdata (ram_rdata)
    );

    // error stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b       <= i_item;
            r_fwd_hit <= fwd_hit;
            r_fwd_val <= fwd_val;
        end
        if (new_tail) begin
            r_tail_addr <= r_b.col;
            r_tail_val  <= new_left;
        end
        if (b_done) begin
            r_out_dot       <= dot;
            r_out_row_end   <= r_b.last_col;
            r_out_frame_end <= r_b.last_col && r_b.last_row;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld       <= 1'b0;
            r_out_vld     <= 1'b0;
            r_tail_vld    <= 1'b0;
            r_right_carry <= '0;
            r_pend_bl     <= '0;
            r_pend_b      <= '0;
        end else begin
            if (adv) begin
                r_b_vld <= 1'b1;
            end else if (b_done) begin
                r_b_vld <= 1'b0;
            end
            if (b_done) begin
                r_out_vld <= 1'b1;
            end else if (o_dot.ready) begin
                r_out_vld <= 1'b0;
            end
            r_tail_vld    <= n_tail_vld;
            r_right_carry <= n_right_carry;
            r_pend_bl     <= n_pend_bl;
            r_pend_b      <= n_pend_b;
        end
    end

    assign o_dot.valid     = r_out_vld;
    assign o_dot.dot_on    = r_out_dot;
    assign o_dot.row_end   = r_out_row_end;
    assign o_dot.frame_end = r_out_frame_end;

endmodule

[verif/floyd_steinberg_dither_checker.sv]
`timescale 1ns / 100ps

module floyd_steinberg_dither_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  fsd_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [fsd_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_pix_valid,
    input  logic                        i_pix_ready,
    input  fsd_pkg::t_pixel             i_pixel,
    input  logic                        i_dot_valid,
    input  logic                        i_dot_ready,
    input  logic                        i_dot_on,
    input  logic                        i_row_end,
    input  logic                        i_frame_end,
    output int                          o_open_count,
    output int                          o_fail_count,
    output int                          o_dot_count
);
    import fsd_pkg::*;

    typedef struct packed {
        logic dot_on;
        logic row_end;
        logic frame_end;
    } t_dot_due;

    // shadow geometry and diffusion state
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_err                below_errs [MAX_WIDTH];
    t_err                carry_right;
    t_err                held_below_left;
    t_err                held_below;
    t_col                col_pos;
    t_row                row_pos;

    t_dot_due            dots_due [$];
    int                  fails;
    int                  checked;

    function automatic int clamp_err(input int v);
        if (v > int'(ERR_MAX)) begin
            return int'(ERR_MAX);
        end
        if (v < int'(ERR_MIN)) begin
            return int'(ERR_MIN);
        end
        return v;
    endfunction

    // quantize one pixel and spread its error, advancing the raster position
    function automatic t_dot_due diffuse_pixel(input t_pixel pix);
        int       w;
        int       h;
        int       x;
        int       y;
        logic     col_last;
        logic     row_last;
        logic     dot;
        int       above;
        int       level;
        int       qerr;
        int       left_acc;
        t_dot_due r;

        w = int'(width_reg);
        h = int'(height_reg);
        x = int'(col_pos);
        y = int'(row_pos);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;

        col_last = (x + 1 >= w);
        row_last = (y + 1 >= h);

        // the first row of a frame has nothing diffused from above
        above = (y > 0) ? int'(below_errs[x]) : 0;
        level = clamp_err(int'(pix) + int'(carry_right) + above);
        dot   = (level > int'(ON_THRESH));
        qerr  = dot ? level - int'(DOT_LEVEL) : level;

        carry_right = col_last ? '0 : t_err'(clamp_err(qerr * int'(WT_RIGHT) / SHARE_DIV));

        // next-row shares, nothing below the last row
        if (!row_last) begin
            if (x > 0) begin
                below_errs[x-1] = t_err'(clamp_err(int'(held_below_left)
                                                   + qerr * int'(WT_BLEFT) / SHARE_DIV));
            end
            left_acc = clamp_err(int'(held_below) + qerr * int'(WT_BELOW) / SHARE_DIV);
            if (col_last) begin
                below_errs[x]   = t_err'(left_acc);
                held_below_left = '0;
                held_below      = '0;
            end else begin
                held_below_left = t_err'(left_acc);
                held_below      = t_err'(clamp_err(qerr / SHARE_DIV));
            end
        end else begin
            held_below_left = '0;
            held_below      = '0;
        end

        if (col_last) begin
            col_pos = '0;
            row_pos = row_last ? '0 : t_row'(y + 1);
        end else begin
            col_pos = t_col'(x + 1);
        end

        r.dot_on    = dot;
        r.row_end   = col_last;
        r.frame_end = col_last && row_last;
        return r;
    endfunction

    // watch config writes, pixel requests and dot results
    always @(posedge i_clk) begin : watch
        t_dot_due want;
        if (!i_rst_n) begin
            width_reg       = 13'd640;
            height_reg      = 16'd480;
            carry_right     = '0;
            held_below_left = '0;
            held_below      = '0;
            col_pos         = '0;
            row_pos         = '0;
            dots_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH: begin
                        width_reg = i_cfg_data[WIDTH_W-1:0];
                    end
                    CFG_HEIGHT: begin
                        height_reg = i_cfg_data[HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_dot_valid && i_dot_ready) begin
                if (dots_due.size() == 0) begin
                    $error("dot result with no pixel request pending: %s %0b %0b %0b",
                           "dot_on/row_end/frame_end", i_dot_on, i_row_end, i_frame_end);
                    fails++;
                end else begin
                    want = dots_due.pop_front();
                    checked++;
                    if (i_dot_on !== want.dot_on) begin
                        $error("dot_on: expected %0b, got %0b", want.dot_on, i_dot_on);
                        fails++;
                    end
                    if (i_row_end !== want.row_end) begin
                        $error("row_end: expected %0b, got %0b", want.row_end, i_row_end);
                        fails++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, i_frame_end);
                        fails++;
                    end
                end
            end

            if (i_pix_valid && i_pix_ready) begin
                dots_due.push_back(diffuse_pixel(i_pixel));
            end
        end
        o_open_count <= dots_due.size();
        o_fail_count <= fails;
        o_dot_count  <= checked;
    end

endmodule

[verif/floyd_steinberg_dither_top_tb.sv]
`timescale 1ns / 100ps

module floyd_steinberg_dither_top_tb;
    import fsd_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PIXELS = 1500;
    localparam int CAP_PIXELS    = 200;
    localparam int MAX_HEIGHT    = 65535;

    // grey-level mixes for a run of pixel requests
    typedef enum int {
        TONE_UNIFORM,
        TONE_NEAR,
        TONE_EXTREME,
        TONE_FLAT,
        TONE_DARK
    } t_tone;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    t_cfg_idx           cfg_idx;
    logic [CFG_DW-1:0]  cfg_data;

    fsd_pix_if pix_if();
    fsd_dot_if dot_if();

    int open_count;
    int fail_count;
    int dot_count;
    int burst_left;
    int pixels_sent;
    int frames_sent;
    int geometry_writes;
    int cycle_count;
    int eff_w;
    int eff_h;
    bit hold_off_go;
    bit hold_off_done;

    floyd_steinberg_dither_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_dot      (dot_if)
    );

    floyd_steinberg_dither_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix_valid  (pix_if.valid),
        .i_pix_ready  (pix_if.ready),
        .i_pixel      (pix_if.pixel_in),
        .i_dot_valid  (dot_if.valid),
        .i_dot_ready  (dot_if.ready),
        .i_dot_on     (dot_if.dot_on),
        .i_row_end    (dot_if.row_end),
        .i_frame_end  (dot_if.frame_end),
        .o_open_count (open_count),
        .o_fail_count (fail_count),
        .o_dot_count  (dot_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // effective size of a geometry register value
    function automatic int clip(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_pixel pick_pixel(input t_tone tone, input t_pixel flat);
        case (tone)
            TONE_NEAR:    return t_pixel'($urandom_range(110, 150));
            TONE_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            TONE_FLAT:    return flat;
            TONE_DARK:    return t_pixel'($urandom_range(0, 40));
            default:      return t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel request, sent in bursts with random gaps
    task automatic send_pixel(input t_pixel p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= p;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        burst_left--;
        pixels_sent++;
    endtask

    task automatic send_run(input int n, input t_tone tone);
        t_pixel flat;
        flat = t_pixel'($urandom_range(0, 255));
        repeat (n) send_pixel(pick_pixel(tone, flat));
    endtask

    // stop sending and let every outstanding dot come back
    task automatic drain();
        pix_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [CFG_DW-1:0] w_data,
                                  input logic [CFG_DW-1:0] h_data);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDTH;
        cfg_data <= w_data;
        @(posedge i_clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= h_data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        eff_w = clip(int'(w_data[WIDTH_W-1:0]), MAX_WIDTH);
        eff_h = clip(int'(h_data), MAX_HEIGHT);
        geometry_writes++;
    endtask

    // shrink the geometry partway into a frame, then finish that frame
    task automatic shrink_mid_frame(input int sent, input logic [CFG_DW-1:0] w_data,
                                    input logic [CFG_DW-1:0] h_data, input t_tone tone);
        int x;
        int y;
        int w_new;
        int h_new;
        int left;
        x     = sent % eff_w;
        y     = sent / eff_w;
        w_new = clip(int'(w_data[WIDTH_W-1:0]), MAX_WIDTH);
        h_new = clip(int'(h_data), MAX_HEIGHT);
        // a column at or past the new last one closes the row
        left  = (x >= w_new - 1) ? 1 : w_new - x;
        if (y < h_new - 1) left += (h_new - 1 - y) * w_new;
        drain();
        write_geometry(w_data, h_data);
        send_run(left, tone);
        frames_sent++;
    endtask

    // receiver stalls, plus one long hold-off on request
    initial begin : dot_sink
        int mode;
        int span;
        dot_if.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 300);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_off_go && !hold_off_done) begin
                    dot_if.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    hold_off_done = 1'b1;
                end
                case (mode)
                    0:       dot_if.ready <= 1'b1;
                    1:       dot_if.ready <= ($urandom_range(0, 1) != 0);
                    2:       dot_if.ready <= ($urandom_range(0, 9) != 0);
                    default: dot_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d dots still due", cycle_count, open_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int                part;
        int                total;
        int                nframes;
        int                pick;
        int                hmax;
        int                random_start;
        logic [CFG_DW-1:0] w_data;
        logic [CFG_DW-1:0] h_data;
        t_tone             tone;

        burst_left      = 0;
        pixels_sent     = 0;
        frames_sent     = 0;
        geometry_writes = 0;
        eff_w           = 640;
        eff_h           = 480;
        hold_off_go     = 1'b0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_WIDTH;
        cfg_data        <= '0;
        pix_if.valid    <= 1'b0;
        pix_if.pixel_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: black, white and both sides of the threshold
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd129);
        send_pixel(8'd127);
        // narrowing mid-row past the current column ends that row
        shrink_mid_frame(5, 16'd3, 16'd2, TONE_EXTREME);

        // single column
        drain();
        write_geometry(16'd1, 16'd3);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd100);
        frames_sent++;

        // zero width and height act as one
        drain();
        write_geometry(16'd0, 16'd0);
        send_pixel(8'd129);
        send_pixel(8'd128);
        frames_sent += 2;

        // tallest frame, cut short by lowering the height mid-frame
        drain();
        write_geometry(16'd2, 16'hFFFF);
        send_run(7, TONE_NEAR);
        shrink_mid_frame(7, 16'd2, 16'd2, TONE_NEAR);

        // width register past the line size, while the receiver holds off
        drain();
        write_geometry(16'hFFFF, 16'd2);
        hold_off_go = 1'b1;
        send_run(CAP_PIXELS, TONE_UNIFORM);
        shrink_mid_frame(CAP_PIXELS, 16'd60, 16'd2, TONE_UNIFORM);

        // random geometries, mostly small frames
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            drain();
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                w_data = 16'd0;
            end else if (pick == 1) begin
                w_data = 16'd1;
            end else if (pick == 2) begin
                w_data = CFG_DW'($urandom_range(129, 700));
            end else if (pick < 10) begin
                w_data = CFG_DW'($urandom_range(17, 128));
            end else begin
                w_data = CFG_DW'($urandom_range(2, 16));
            end
            hmax = 600 / clip(int'(w_data), MAX_WIDTH);
            if (hmax < 1) hmax = 1;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                h_data = 16'd0;
            end else if (pick == 1) begin
                h_data = 16'd1;
            end else begin
                h_data = CFG_DW'($urandom_range(1, hmax));
            end
            write_geometry(w_data, h_data);

            nframes = $urandom_range(1, 2);
            repeat (nframes) begin
                tone  = t_tone'($urandom_range(0, 4));
                total = eff_w * eff_h;
                if ($urandom_range(0, 4) == 0 && total > 1) begin
                    part = $urandom_range(1, total - 1);
                    send_run(part, tone);
                    shrink_mid_frame(part, CFG_DW'($urandom_range(0, eff_w)),
                                     CFG_DW'($urandom_range(0, eff_h)), tone);
                end else begin
                    send_run(total, tone);
                    frames_sent++;
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("run: %0d pixel requests in %0d frames across %0d geometry writes",
                 pixels_sent, frames_sent, geometry_writes);
        $display("run: %0d dots checked, one %0d-cycle output hold-off, %s",
                 dot_count, LONG_HOLD, "widths from 1 up to an oversized width register");
        if (fail_count == 0 && open_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[files.f]
src/fsd_pkg.sv
src/fsd_pix_if.sv
src/fsd_dot_if.sv
src/fsd_ram.sv
src/fsd_front.sv
src/fsd_queue.sv
src/fsd_back.sv
src/floyd_steinberg_dither_top.sv
verif/floyd_steinberg_dither_checker.sv
verif/floyd_steinberg_dither_top_tb.sv
